// ===== src/kli_pkg.sv =====
// ----------------------------------------------------------------------------
// kli_pkg: shared types and constants for the keyframe linear interpolator
// Holds the command and result word layouts, the key table entry layout and
// the default sizes used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

    localparam int KLI_MAX_KEYS_DEF  = 64;
    localparam int KLI_FRAC_BITS_DEF = 16;

    // Command kinds.
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [5:0]         key_slot;
        logic [31:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]        sample_time;
    } item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               factor_clamped;
    } result_t;

    // One key table entry as held in the key memory.
    typedef struct packed {
        logic [31:0]        time_val;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } key_t;

    localparam int KEY_W = $bits(key_t);

endpackage

`default_nettype wire

// ===== src/keyframe_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core: keyframe track with linear blending
// Key writes fill a table of (time, x, y, z) keys; sample commands search the
// table for the segment and blend the two keys with a saturated factor.
// ----------------------------------------------------------------------------
// Key writes never raise busy. A sample with a single key in use reads that key
// back through S_SINGLE; otherwise busy covers the linear key search, the
// bit-serial divider where it is needed and the shared multiplier used once
// per component. The word is on done in the same cycle that busy falls; one
// sample at a time, and the receiver cannot stall. Reset (rst_n, asynchronous)
// sets keys_in_use to one and the sequencer idle; the key memory is not
// cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_linear_interpolator_core
    import kli_pkg::*;
#(
    parameter int MAX_KEYS  = KLI_MAX_KEYS_DEF,
    parameter int FRAC_BITS = KLI_FRAC_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    // Command channel.
    input  wire logic    start,
    output logic         busy,
    input  wire item_t   item,
    // Result channel.
    output logic         done,
    output result_t      result,
    // Configuration channel (keys_in_use).
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic [6:0] cfg_data
);

    localparam int AW   = $clog2(MAX_KEYS);
    localparam int CNTW = $clog2(FRAC_BITS);
    localparam int FW   = FRAC_BITS + 1;      // factor runs from 0 to one inclusive
    localparam int PW   = FW + 1 + 33;        // signed factor times 33-bit difference
    localparam logic [31:0] MAX_W = 32'(MAX_KEYS);

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_SINGLE   = 12'b0000_0000_0010,
        S_SCAN     = 12'b0000_0000_0100,
        S_FETCH_HI = 12'b0000_0000_1000,
        S_FETCH_LO = 12'b0000_0001_0000,
        S_LOAD     = 12'b0000_0010_0000,
        S_SETUP    = 12'b0000_0100_0000,
        S_DECIDE   = 12'b0000_1000_0000,
        S_DIVIDE   = 12'b0001_0000_0000,
        S_DIFF     = 12'b0010_0000_0000,
        S_MUL      = 12'b0100_0000_0000,
        S_ACC      = 12'b1000_0000_0000
    } state_t;

    // Control registers.
    state_t            state_reg, state_next;
    logic [6:0]        keys_reg, keys_next;
    logic              done_reg, done_next;
    // Working registers.
    logic [AW-1:0]     last_reg, last_next;
    logic [AW-1:0]     scan_reg, scan_next;
    logic [AW-1:0]     seg_reg, seg_next;
    logic [31:0]       t_reg, t_next;
    key_t              hi_reg, hi_next;
    key_t              lo_reg, lo_next;
    logic signed [32:0] num_reg, num_next;
    logic signed [32:0] den_reg, den_next;
    logic [31:0]       rem_reg, rem_next;
    logic [FW-1:0]     f_reg, f_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [1:0]        comp_reg, comp_next;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic              clamp_reg, clamp_next;
    result_t           res_reg, res_next;

    // Key memory ports.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    key_t              ram_wdata;
    logic [KEY_W-1:0]  ram_rdata;
    key_t              ram_q;

    // Helpers.
    logic              accept;
    logic [31:0]       keys_w;
    logic [31:0]       last_w;
    logic              slot_ok;
    logic [32:0]       rem_shift;
    logic              rem_ge;
    logic signed [31:0] comp_start;
    logic signed [31:0] comp_end;
    logic signed [PW-1:0] prod_shifted;
    logic signed [31:0] comp_sum;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;
    assign ram_q     = key_t'(ram_rdata);

    // The number of keys in use is saturated into one to MAX_KEYS; the
    // sequencer keeps the index of the last key in use.
    assign keys_w = {25'b0, keys_reg};
    always_comb
    begin
        if (keys_w == 32'd0)
        begin
            last_w = 32'd0;
        end
        else if (keys_w > MAX_W)
        begin
            last_w = MAX_W - 32'd1;
        end
        else
        begin
            last_w = keys_w - 32'd1;
        end
    end

    // Key writes go straight into the memory when the command is accepted.
    // Slots beyond the table are dropped.
    assign slot_ok   = ({26'b0, item.key_slot} < MAX_W);
    assign ram_we    = accept && (item.kind == KIND_WRITE) && slot_ok;
    assign ram_waddr = AW'({26'b0, item.key_slot});
    always_comb
    begin
        ram_wdata.time_val = item.key_time;
        ram_wdata.x        = item.key_x;
        ram_wdata.y        = item.key_y;
        ram_wdata.z        = item.key_z;
    end

    // Read address: the memory registers its read data, so the key shown here appears in the following cycle.
    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                ram_raddr = (last_w == 32'd0) ? '0 : AW'(1);
            end
            S_SCAN:
            begin
                ram_raddr = scan_reg + AW'(1);
            end
            S_FETCH_HI:
            begin
                ram_raddr = seg_reg + AW'(1);
            end
            default:
            begin
                ram_raddr = seg_reg;
            end
        endcase
    end

    kli_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // One restoring division step: the remainder stays below the divisor.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg[31:0]});

    // Component selection for the shared blend datapath.
    always_comb
    begin
        case (comp_reg)
            COMP_X:
            begin
                comp_start = lo_reg.x;
                comp_end   = hi_reg.x;
            end
            COMP_Y:
            begin
                comp_start = lo_reg.y;
                comp_end   = hi_reg.y;
            end
            default:
            begin
                comp_start = lo_reg.z;
                comp_end   = hi_reg.z;
            end
        endcase
    end

    // An arithmetic shift of the product is its floor; the blended value lies
    // between the two keys, so the low 32 bits of the sum are exact.
    assign prod_shifted = prod_reg >>> FRAC_BITS;
    assign comp_sum     = comp_start + prod_shifted[31:0];

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        keys_next  = keys_reg;
        done_next  = 1'b0;
        last_next  = last_reg;
        scan_next  = scan_reg;
        seg_next   = seg_reg;
        t_next     = t_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        f_next     = f_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        diff_next  = diff_reg;
        prod_next  = prod_reg;
        clamp_next = clamp_reg;
        res_next   = res_reg;

        if (cfg_valid && cfg_ready)
        begin
            keys_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.kind == KIND_SAMPLE))
                begin
                    t_next    = item.sample_time;
                    last_next = AW'(last_w);
                    scan_next = AW'(1);
                    seg_next  = '0;
                    if (last_w == 32'd0)
                    begin
                        state_next = S_SINGLE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SINGLE:
            begin
                res_next.out_x          = ram_q.x;
                res_next.out_y          = ram_q.y;
                res_next.out_z          = ram_q.z;
                res_next.factor_clamped = 1'b0;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            S_SCAN:
            begin
                // The memory now holds the key at scan_reg: the first key later
                // than the sample time closes the segment.
                if (ram_q.time_val > t_reg)
                begin
                    seg_next   = scan_reg - AW'(1);
                    state_next = S_FETCH_HI;
                end
                else if (scan_reg == last_reg)
                begin
                    seg_next   = '0;
                    state_next = S_FETCH_HI;
                end
                else
                begin
                    scan_next = scan_reg + AW'(1);
                end
            end
            S_FETCH_HI:
            begin
                state_next = S_FETCH_LO;
            end
            S_FETCH_LO:
            begin
                hi_next    = ram_q;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                lo_next    = ram_q;
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                num_next   = $signed({1'b0, t_reg}) - $signed({1'b0, lo_reg.time_val});
                den_next   = $signed({1'b0, hi_reg.time_val})
                             - $signed({1'b0, lo_reg.time_val});
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                f_next     = '0;
                clamp_next = 1'b0;
                comp_next  = COMP_X;
                cnt_next   = '0;
                rem_next   = num_reg[31:0];
                state_next = S_DIFF;
                if (den_reg[32] || (den_reg == 33'sd0))
                begin
                    // Equal or descending key times: the start key is taken.
                    clamp_next = 1'b0;
                end
                else if (num_reg[32] || (num_reg == 33'sd0))
                begin
                    clamp_next = num_reg[32];
                end
                else if (num_reg >= den_reg)
                begin
                    f_next     = FW'(1) << FRAC_BITS;
                    clamp_next = (num_reg != den_reg);
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (rem_ge)
                begin
                    rem_next = 32'(rem_shift - {1'b0, den_reg[31:0]});
                end
                else
                begin
                    rem_next = rem_shift[31:0];
                end
                f_next   = {f_reg[FW-2:0], rem_ge};
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(FRAC_BITS - 1))
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                diff_next  = $signed({comp_end[31], comp_end})
                             - $signed({comp_start[31], comp_start});
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PW'($signed({1'b0, f_reg}) * diff_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                case (comp_reg)
                    COMP_X:
                    begin
                        res_next.out_x = comp_sum;
                    end
                    COMP_Y:
                    begin
                        res_next.out_y = comp_sum;
                    end
                    default:
                    begin
                        res_next.out_z = comp_sum;
                    end
                endcase
                if (comp_reg == COMP_Z)
                begin
                    res_next.factor_clamped = clamp_reg;
                    done_next               = 1'b1;
                    state_next              = S_IDLE;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            keys_reg  <= 7'd1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            keys_reg  <= keys_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        scan_reg  <= scan_next;
        seg_reg   <= seg_next;
        t_reg     <= t_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        f_reg     <= f_next;
        cnt_reg   <= cnt_next;
        comp_reg  <= comp_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        clamp_reg <= clamp_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

// ===== src/kli_ram.sv =====
// ----------------------------------------------------------------------------
// kli_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
